[rtl/core/bmds_pkg.sv]
// ----------------------------------------------------------------------------
// bmds_pkg
// Shared types and constants of the breadth-first max-degree search core.
// ----------------------------------------------------------------------------
package bmds_pkg;

  // fixed field widths of the command and result ports
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VTX_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEG_W    = 4;

  // default sizing
  localparam int unsigned VERTICES_DEF   = 16;
  localparam int unsigned MAX_DEGREE_DEF = 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_VERTEX = 2'd0,
    CMD_ADD_EDGE   = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_DUP          = 3'd1,
    ST_SRC_MISSING  = 3'd2,
    ST_DST_MISSING  = 3'd3,
    ST_BOTH_MISSING = 3'd4,
    ST_FULL         = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_POP,
    S_CUR,
    S_CNT,
    S_NB
  } state_e;

  // one finished transaction from the sequencer
  typedef struct packed {
    logic             done;
    status_e          status;
    logic [VTX_W-1:0] vertex;
    logic [DEG_W-1:0] degree;
  } result_t;

endpackage

[rtl/core/bmds_ram.sv]
// ----------------------------------------------------------------------------
// bmds_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmds_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bmds_seq.sv]
// ----------------------------------------------------------------------------
// bmds_seq
// Command sequencer: presence and visited flags, edge insertion and the
// breadth-first walk over the degree, neighbor and queue memories.
// ----------------------------------------------------------------------------
module bmds_seq #(
  parameter int unsigned VERTICES   = bmds_pkg::VERTICES_DEF,
  parameter int unsigned MAX_DEGREE = bmds_pkg::MAX_DEGREE_DEF,
  localparam int unsigned VW  = $clog2(VERTICES),
  localparam int unsigned CW  = $clog2(MAX_DEGREE + 1),
  localparam int unsigned NAW = $clog2(VERTICES * MAX_DEGREE)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [bmds_pkg::CMD_W-1:0]   cmd_i,
  input  logic [bmds_pkg::VTX_W-1:0]   first_vertex_i,
  input  logic [bmds_pkg::VTX_W-1:0]   second_vertex_i,
  output bmds_pkg::result_t            result_o,
  // degree memory
  output logic                         cnt_we_o,
  output logic [VW-1:0]                cnt_waddr_o,
  output logic [CW-1:0]                cnt_wdata_o,
  output logic [VW-1:0]                cnt_raddr_o,
  input  logic [CW-1:0]                cnt_rdata_i,
  // neighbor memory
  output logic                         nbr_we_o,
  output logic [NAW-1:0]               nbr_waddr_o,
  output logic [bmds_pkg::VTX_W-1:0]   nbr_wdata_o,
  output logic [NAW-1:0]               nbr_raddr_o,
  input  logic [bmds_pkg::VTX_W-1:0]   nbr_rdata_i,
  // walk queue memory
  output logic                         q_we_o,
  output logic [VW-1:0]                q_waddr_o,
  output logic [VW-1:0]                q_wdata_o,
  output logic [VW-1:0]                q_raddr_o,
  input  logic [VW-1:0]                q_rdata_i
);

  bmds_pkg::state_e state_q, state_d;

  logic [VERTICES-1:0] present_q, present_d;
  logic [VERTICES-1:0] visited_q, visited_d;
  logic [VW:0]         head_q, head_d;
  logic [VW:0]         tail_q, tail_d;

  logic [VW-1:0]                src_q, src_d;
  logic [bmds_pkg::VTX_W-1:0]   dst_q, dst_d;
  logic [VW-1:0]                cur_q, cur_d;
  logic [CW-1:0]                n_q, n_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [VW-1:0]                best_q, best_d;
  logic [CW-1:0]                bestdeg_q, bestdeg_d;

  logic          a_ok, b_ok;
  logic [VW-1:0] a_idx, b_idx, nb_idx;
  logic          nb_new;
  logic [CW-1:0] n_clip;

  // neighbor memory address of a list slot
  function automatic logic [NAW-1:0] nbr_addr(input logic [VW-1:0] v,
                                              input logic [CW-1:0] i);
    nbr_addr = NAW'(v) * NAW'(MAX_DEGREE) + NAW'(i);
  endfunction

  // operand decode
  assign a_idx  = VW'(first_vertex_i);
  assign b_idx  = VW'(second_vertex_i);
  assign a_ok   = (32'(first_vertex_i) < VERTICES) && present_q[a_idx];
  assign b_ok   = (32'(second_vertex_i) < VERTICES) && present_q[b_idx];
  assign nb_idx = VW'(nbr_rdata_i);
  assign nb_new = (32'(nbr_rdata_i) < VERTICES) && !visited_q[nb_idx] &&
                  (tail_q < (VW+1)'(VERTICES));
  assign n_clip = (32'(cnt_rdata_i) > MAX_DEGREE) ? CW'(MAX_DEGREE) : cnt_rdata_i;

  assign busy = (state_q != bmds_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bmds_pkg::S_IDLE;
      present_q <= '0;
      visited_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      visited_q <= visited_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
    end
  end

  // walk operands
  always_ff @(posedge clk_i) begin
    src_q     <= src_d;
    dst_q     <= dst_d;
    cur_q     <= cur_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    best_q    <= best_d;
    bestdeg_q <= bestdeg_d;
  end

  // next state, memory requests and results
  always_comb begin
    state_d   = state_q;
    present_d = present_q;
    visited_d = visited_q;
    head_d    = head_q;
    tail_d    = tail_q;
    src_d     = src_q;
    dst_d     = dst_q;
    cur_d     = cur_q;
    n_d       = n_q;
    idx_d     = idx_q;
    best_d    = best_q;
    bestdeg_d = bestdeg_q;

    cnt_we_o    = 1'b0;
    cnt_waddr_o = '0;
    cnt_wdata_o = '0;
    cnt_raddr_o = '0;
    nbr_we_o    = 1'b0;
    nbr_waddr_o = '0;
    nbr_wdata_o = '0;
    nbr_raddr_o = '0;
    q_we_o      = 1'b0;
    q_waddr_o   = '0;
    q_wdata_o   = '0;
    q_raddr_o   = '0;

    result_o        = '0;
    result_o.status = bmds_pkg::ST_OK;

    case (state_q)
      bmds_pkg::S_IDLE: begin
        if (start) begin
          case (bmds_pkg::cmd_e'(cmd_i))
            bmds_pkg::CMD_ADD_VERTEX: begin
              result_o.done = 1'b1;
              if (32'(first_vertex_i) >= VERTICES) begin
                result_o.status = bmds_pkg::ST_SRC_MISSING;
              end else if (present_q[a_idx]) begin
                result_o.status = bmds_pkg::ST_DUP;
              end else begin
                present_d[a_idx] = 1'b1;
                cnt_we_o         = 1'b1;
                cnt_waddr_o      = a_idx;
                cnt_wdata_o      = '0;
              end
            end
            bmds_pkg::CMD_ADD_EDGE: begin
              if (!a_ok && !b_ok) begin
                result_o.done   = 1'b1;
                result_o.status = bmds_pkg::ST_BOTH_MISSING;
              end else if (!a_ok) begin
                result_o.done   = 1'b1;
                result_o.status = bmds_pkg::ST_SRC_MISSING;
              end else if (!b_ok) begin
                result_o.done   = 1'b1;
                result_o.status = bmds_pkg::ST_DST_MISSING;
              end else begin
                cnt_raddr_o = a_idx;
                src_d       = a_idx;
                dst_d       = second_vertex_i;
                state_d     = bmds_pkg::S_EDGE;
              end
            end
            bmds_pkg::CMD_QUERY: begin
              if (!a_ok) begin
                result_o.done   = 1'b1;
                result_o.status = bmds_pkg::ST_SRC_MISSING;
              end else begin
                visited_d        = '0;
                visited_d[a_idx] = 1'b1;
                q_we_o           = 1'b1;
                q_waddr_o        = '0;
                q_wdata_o        = a_idx;
                head_d           = '0;
                tail_d           = (VW+1)'(1);
                best_d           = a_idx;
                bestdeg_d        = '0;
                state_d          = bmds_pkg::S_POP;
              end
            end
            default: begin
              result_o.done = 1'b1;
            end
          endcase
        end
      end

      // degree of the source is back: append or report a full list
      bmds_pkg::S_EDGE: begin
        result_o.done = 1'b1;
        state_d       = bmds_pkg::S_IDLE;
        if (32'(cnt_rdata_i) >= MAX_DEGREE) begin
          result_o.status = bmds_pkg::ST_FULL;
        end else begin
          nbr_we_o    = 1'b1;
          nbr_waddr_o = nbr_addr(src_q, cnt_rdata_i);
          nbr_wdata_o = dst_q;
          cnt_we_o    = 1'b1;
          cnt_waddr_o = src_q;
          cnt_wdata_o = cnt_rdata_i + CW'(1);
        end
      end

      // dequeue the next vertex or finish the walk
      bmds_pkg::S_POP: begin
        if (head_q == tail_q) begin
          result_o.done   = 1'b1;
          result_o.vertex = bmds_pkg::VTX_W'(best_q);
          result_o.degree = bmds_pkg::DEG_W'(bestdeg_q);
          state_d         = bmds_pkg::S_IDLE;
        end else begin
          q_raddr_o = head_q[VW-1:0];
          head_d    = head_q + (VW+1)'(1);
          state_d   = bmds_pkg::S_CUR;
        end
      end

      // dequeued vertex is back: fetch its degree
      bmds_pkg::S_CUR: begin
        cur_d       = q_rdata_i;
        cnt_raddr_o = q_rdata_i;
        state_d     = bmds_pkg::S_CNT;
      end

      // degree is back: track the best and start the neighbor reads
      bmds_pkg::S_CNT: begin
        n_d = n_clip;
        if (n_clip > bestdeg_q) begin
          best_d    = cur_q;
          bestdeg_d = n_clip;
        end
        if (n_clip == '0) begin
          state_d = bmds_pkg::S_POP;
        end else begin
          nbr_raddr_o = nbr_addr(cur_q, '0);
          idx_d       = CW'(1);
          state_d     = bmds_pkg::S_NB;
        end
      end

      // one neighbor per cycle: enqueue unvisited ones
      bmds_pkg::S_NB: begin
        if (nb_new) begin
          visited_d[nb_idx] = 1'b1;
          q_we_o            = 1'b1;
          q_waddr_o         = tail_q[VW-1:0];
          q_wdata_o         = nb_idx;
          tail_d            = tail_q + (VW+1)'(1);
        end
        if (idx_q < n_q) begin
          nbr_raddr_o = nbr_addr(cur_q, idx_q);
          idx_d       = idx_q + CW'(1);
        end else begin
          state_d = bmds_pkg::S_POP;
        end
      end

      default: begin
        state_d = bmds_pkg::S_IDLE;
      end
    endcase
  end

  // queue pointers stay ordered and bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= (VW+1)'(VERTICES)))
    else $error("walk queue pointers out of order");

  // a finished transaction always leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.done |=> (state_q == bmds_pkg::S_IDLE))
    else $error("sequencer not idle after result");

  // a dequeued vertex is only taken right after a queue read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmds_pkg::S_CUR) |-> ($past(state_q) == bmds_pkg::S_POP))
    else $error("queue data used without a read");

  // at least one vertex stays marked while walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmds_pkg::S_POP) |-> (visited_q != '0))
    else $error("walk running with no visited vertex");

  // every queue write while reading neighbors advances the tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_we_o && (state_q == bmds_pkg::S_NB)) |=> (tail_q == $past(tail_q) + (VW+1)'(1)))
    else $error("queue write without tail advance");

endmodule

[rtl/core/bfs_max_degree_search_core.sv]
// ----------------------------------------------------------------------------
// bfs_max_degree_search_core
// Directed graph store with add vertex, add edge and a breadth-first query
// that returns the reachable vertex with the most out-edges.
// ----------------------------------------------------------------------------
// Add vertex, unused command and rejected commands give done_o in the cycle
//   after acceptance; add edge first reads the degree memory (S_EDGE), then done_o is registered.
// Query: each dequeued vertex costs a queue read, a degree read and a setup
//   step, then one neighbor per cycle. Add vertex, unused and rejected
//   commands leave the core idle, so a new command can be taken every cycle.
// busy is high while an add edge or query is in flight; the result strobe cannot stall.
// Reset clears presence and visited flags; the memories need no clearing.
// ----------------------------------------------------------------------------
module bfs_max_degree_search_core #(
  parameter int unsigned VERTICES   = bmds_pkg::VERTICES_DEF,
  parameter int unsigned MAX_DEGREE = bmds_pkg::MAX_DEGREE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bmds_pkg::CMD_W-1:0]    cmd_i,
  input  logic [bmds_pkg::VTX_W-1:0]    first_vertex_i,
  input  logic [bmds_pkg::VTX_W-1:0]    second_vertex_i,
  output logic                          done_o,
  output logic [bmds_pkg::STATUS_W-1:0] status_o,
  output logic [bmds_pkg::VTX_W-1:0]    found_vertex_o,
  output logic [bmds_pkg::DEG_W-1:0]    found_degree_o
);

  localparam int unsigned VW  = $clog2(VERTICES);
  localparam int unsigned CW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned NAW = $clog2(VERTICES * MAX_DEGREE);

  bmds_pkg::result_t result;

  logic                       cnt_we;
  logic [VW-1:0]              cnt_waddr, cnt_raddr;
  logic [CW-1:0]              cnt_wdata, cnt_rdata;
  logic                       nbr_we;
  logic [NAW-1:0]             nbr_waddr, nbr_raddr;
  logic [bmds_pkg::VTX_W-1:0] nbr_wdata, nbr_rdata;
  logic                       q_we;
  logic [VW-1:0]              q_waddr, q_wdata, q_raddr, q_rdata;

  logic                          done_q;
  logic [bmds_pkg::STATUS_W-1:0] status_q;
  logic [bmds_pkg::VTX_W-1:0]    vertex_q;
  logic [bmds_pkg::DEG_W-1:0]    degree_q;

  // command sequencer
  bmds_seq #(
    .VERTICES   (VERTICES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .result_o        (result),
    .cnt_we_o        (cnt_we),
    .cnt_waddr_o     (cnt_waddr),
    .cnt_wdata_o     (cnt_wdata),
    .cnt_raddr_o     (cnt_raddr),
    .cnt_rdata_i     (cnt_rdata),
    .nbr_we_o        (nbr_we),
    .nbr_waddr_o     (nbr_waddr),
    .nbr_wdata_o     (nbr_wdata),
    .nbr_raddr_o     (nbr_raddr),
    .nbr_rdata_i     (nbr_rdata),
    .q_we_o          (q_we),
    .q_waddr_o       (q_waddr),
    .q_wdata_o       (q_wdata),
    .q_raddr_o       (q_raddr),
    .q_rdata_i       (q_rdata)
  );

  // out-degree per vertex
  bmds_ram #(
    .WIDTH (CW),
    .DEPTH (VERTICES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // neighbor lists, MAX_DEGREE slots per vertex
  bmds_ram #(
    .WIDTH (bmds_pkg::VTX_W),
    .DEPTH (VERTICES * MAX_DEGREE)
  ) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (nbr_wdata),
    .raddr_i (nbr_raddr),
    .rdata_o (nbr_rdata)
  );

  // breadth-first walk queue
  bmds_ram #(
    .WIDTH (VW),
    .DEPTH (VERTICES)
  ) u_q_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // result strobe register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= result.done;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (result.done) begin
      status_q <= result.status;
      vertex_q <= result.vertex;
      degree_q <= result.degree;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_vertex_o = vertex_q;
  assign found_degree_o = degree_q;

endmodule
